/* rtl/timestamp_ordered_priority_queue_assert.svh */
// Assertion macros for the timestamp ordered priority queue.
// Depends on clk and rst being in scope where a macro is used.
`ifndef TIMESTAMP_ORDERED_PRIORITY_QUEUE_ASSERT_SVH
`define TIMESTAMP_ORDERED_PRIORITY_QUEUE_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define TSQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in priority queue");

// Check that a condition implies another in the following cycle
`define TSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in priority queue");

`endif

/* rtl/tsq_pkg.sv */
// Shared types and constants for the timestamp ordered priority queue.
// No dependencies; used by tsq_cell and the top level.
package tsq_pkg;

  localparam int CAPACITY     = 16;
  localparam int ID_BITS      = 8;
  localparam int REQ_ID_W     = 8;
  localparam int KEY_W        = 64;
  localparam int OCC_W        = 5;
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_POP   = 1'b1;

  // One request as it arrives
  typedef struct packed {
    logic                mode;
    logic [REQ_ID_W-1:0] request_id;
    logic [KEY_W-1:0]    request_time;
    logic [KEY_W-1:0]    sequence_number;
  } req_t;

  // One result as it leaves
  typedef struct packed {
    logic [REQ_ID_W-1:0] popped_id;
    logic                pop_ok;
    logic                push_dropped;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

  // Contents of one cell
  typedef struct packed {
    logic [KEY_W-1:0]   entry_time;
    logic [KEY_W-1:0]   entry_sequence;
    logic [ID_BITS-1:0] entry_identifier;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // Strict ordering on (time, sequence)
  function automatic logic key_less(input logic [KEY_W-1:0] ta, input logic [KEY_W-1:0] sa,
                                    input logic [KEY_W-1:0] tb, input logic [KEY_W-1:0] sb);
    key_less = (ta < tb) || ((ta == tb) && (sa < sb));
  endfunction

endpackage

/* rtl/timestamp_ordered_priority_queue.sv */
// Top level of the timestamp ordered priority queue: request stage, cell chain, result.
// Depends on tsq_pkg, tsq_cell and timestamp_ordered_priority_queue_assert.svh.
//
//   channel   handshake          payload
//   request   start / busy       request (tsq_pkg::req_t)
//   result    done (strobe)      result  (tsq_pkg::res_t)
//
// A request is taken whenever start is high and busy is low; one per cycle.
// Its result is registered after the request stage, with done high for one cycle.
// The cost per request is one 128-bit key compare in every cell, all in parallel.
// Reset (rst, synchronous) empties the queue; busy is high in the cycle after it.
// The result side cannot stall, so start is never held off after that cycle.
`include "timestamp_ordered_priority_queue_assert.svh"

module timestamp_ordered_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tsq_pkg::req_t request,
  output logic          done,
  output tsq_pkg::res_t result
);

  logic                       req_valid;
  tsq_pkg::req_t              req;
  logic [tsq_pkg::CNT_W-1:0]  count;
  logic [tsq_pkg::CNT_W-1:0]  count_next;
  logic                       full;
  logic                       empty;
  tsq_pkg::cell_ctrl_t        ctrl;
  tsq_pkg::entry_t            new_entry;
  tsq_pkg::entry_t            cell_entry [tsq_pkg::CAPACITY];
  logic [tsq_pkg::CAPACITY-1:0] occ;
  logic [tsq_pkg::CAPACITY-1:0] less;
  tsq_pkg::res_t              result_next;

  // Hold off requests in the cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
    if (start && !busy) begin
      req <= request;
    end
  end

  assign full  = (count == tsq_pkg::CNT_W'(tsq_pkg::CAPACITY));
  assign empty = (count == '0);

  assign ctrl.push = req_valid && (req.mode == tsq_pkg::MODE_PUSH) && !full;
  assign ctrl.pop  = req_valid && (req.mode == tsq_pkg::MODE_POP) && !empty;

  assign new_entry.entry_time       = req.request_time;
  assign new_entry.entry_sequence   = req.sequence_number;
  assign new_entry.entry_identifier = req.request_id[tsq_pkg::ID_BITS-1:0];

  // Build the chain of cells
  for (genvar i = 0; i < tsq_pkg::CAPACITY; i++) begin : g_cell
    logic            prev_occ;
    logic            prev_lt;
    tsq_pkg::entry_t left_e;
    tsq_pkg::entry_t right_e;

    assign occ[i] = (count > tsq_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
      assign prev_lt  = 1'b0;
      assign left_e   = new_entry;
    end else begin : g_body
      assign prev_occ = occ[i-1];
      assign prev_lt  = less[i-1];
      assign left_e   = cell_entry[i-1];
    end

    if (i == tsq_pkg::CAPACITY - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end

    tsq_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .new_entry     (new_entry),
      .occupied      (occ[i]),
      .prev_occupied (prev_occ),
      .prev_less     (prev_lt),
      .left_entry    (left_e),
      .right_entry   (right_e),
      .entry         (cell_entry[i]),
      .less          (less[i])
    );
  end

  // Advance the occupancy
  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + tsq_pkg::CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - tsq_pkg::CNT_W'(1);
    end
  end

  // Form the result
  always_comb begin
    result_next.popped_id    = '0;
    result_next.pop_ok       = ctrl.pop;
    result_next.push_dropped = req_valid && (req.mode == tsq_pkg::MODE_PUSH) && full;
    result_next.occupancy    = tsq_pkg::OCC_W'(count_next);
    if (ctrl.pop) begin
      result_next.popped_id = tsq_pkg::REQ_ID_W'(cell_entry[0].entry_identifier);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= req_valid;
    end
    result <= result_next;
  end

  `TSQ_ASSERT_NOW(a_count_bound, 1'b1, count <= tsq_pkg::CNT_W'(tsq_pkg::CAPACITY))
  `TSQ_ASSERT_NOW(a_flags_exclusive, done, !(result.pop_ok && result.push_dropped))
  `TSQ_ASSERT_NOW(a_occ_matches, done, result.occupancy == tsq_pkg::OCC_W'(count))
  `TSQ_ASSERT_NEXT(a_empty_pop, req_valid && (req.mode == tsq_pkg::MODE_POP) && empty,
                   done && !result.pop_ok && (result.popped_id == '0))
  `TSQ_ASSERT_NEXT(a_head_popped, ctrl.pop,
                   result.popped_id ==
                   tsq_pkg::REQ_ID_W'($past(cell_entry[0].entry_identifier)))

endmodule

/* rtl/tsq_cell.sv */
// One slot of the sorted chain: holds an entry, shifts right on push, left on pop.
// Depends on tsq_pkg.
module tsq_cell (
  input  logic                clk,
  input  tsq_pkg::cell_ctrl_t ctrl,
  input  tsq_pkg::entry_t     new_entry,
  input  logic                occupied,
  input  logic                prev_occupied,
  input  logic                prev_less,
  input  tsq_pkg::entry_t     left_entry,
  input  tsq_pkg::entry_t     right_entry,
  output tsq_pkg::entry_t     entry,
  output logic                less
);

  logic take_new;

  // New key goes before this entry
  assign less = occupied && tsq_pkg::key_less(new_entry.entry_time, new_entry.entry_sequence,
                                              entry.entry_time, entry.entry_sequence);

  // Insert here when the left neighbour stays and this slot moves or is the first free one
  assign take_new = !prev_less && (less || (!occupied && prev_occupied));

  // Shift, insert or hold
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      entry <= right_entry;
    end else if (ctrl.push) begin
      if (prev_less) begin
        entry <= left_entry;
      end else if (take_new) begin
        entry <= new_entry;
      end
    end
  end

endmodule

/* bench/timestamp_ordered_priority_queue_tb.sv */
// Self-checking bench for timestamp_ordered_priority_queue: directed table then random requests.
// Depends on tsq_pkg and the top level only; expected results come from a behavioural queue.
`timescale 1ns / 100ps

module timestamp_ordered_priority_queue_tb;
  import tsq_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 3;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int PHASE_ITEMS   = (RANDOM_ITEMS + 2) / 3;
  localparam int BIAS_RUN      = 40;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PLAN_ROWS     = 12;

  // One row of the directed table; a row may repeat with id rising and time falling
  typedef struct packed {
    logic                mode;
    logic [REQ_ID_W-1:0] id;
    logic [KEY_W-1:0]    req_time;
    logic [KEY_W-1:0]    req_seq;
    logic [4:0]          reps;
    logic                has_result;
    res_t                result;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t request = '0;
  res_t result;

  // Typed-in expectation travelling with the current request
  logic typed_valid = 1'b0;
  res_t typed_result = '0;

  // Behavioural copy of the queue contents, head at slot 0
  logic [KEY_W-1:0]   slot_time [CAPACITY];
  logic [KEY_W-1:0]   slot_seq  [CAPACITY];
  logic [ID_BITS-1:0] slot_id   [CAPACITY];
  int unsigned        slot_count = 0;

  res_t pending_results[$];

  int unsigned gap_pct = 27;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned pushes = 0, refused = 0, pops = 0, empty_pops = 0, checked = 0;

  plan_row_t plan [PLAN_ROWS];

  timestamp_ordered_priority_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic res_t outcome(input logic [REQ_ID_W-1:0] popped, input logic ok,
                                   input logic dropped, input logic [OCC_W-1:0] occ);
    res_t r;
    r.popped_id    = popped;
    r.pop_ok       = ok;
    r.push_dropped = dropped;
    r.occupancy    = occ;
    return r;
  endfunction

  // Apply one request to the queue copy and return the result it should give
  function automatic res_t apply_request(input req_t r);
    res_t        res;
    int unsigned pos;
    res = '0;
    if (r.mode == MODE_PUSH) begin
      if (slot_count >= CAPACITY) begin
        res.push_dropped = 1'b1;
      end else begin
        // insert after every entry whose key is not greater than the new one
        pos = slot_count;
        for (int unsigned i = 0; i < slot_count; i++) begin
          if ((r.request_time < slot_time[i]) ||
              (r.request_time == slot_time[i] && r.sequence_number < slot_seq[i])) begin
            pos = i;
            break;
          end
        end
        for (int unsigned i = slot_count; i > pos; i--) begin
          slot_time[i] = slot_time[i-1];
          slot_seq[i]  = slot_seq[i-1];
          slot_id[i]   = slot_id[i-1];
        end
        slot_time[pos] = r.request_time;
        slot_seq[pos]  = r.sequence_number;
        slot_id[pos]   = r.request_id[ID_BITS-1:0];
        slot_count++;
      end
    end else if (slot_count > 0) begin
      res.popped_id = REQ_ID_W'(slot_id[0]);
      res.pop_ok    = 1'b1;
      for (int unsigned i = 0; i + 1 < slot_count; i++) begin
        slot_time[i] = slot_time[i+1];
        slot_seq[i]  = slot_seq[i+1];
        slot_id[i]   = slot_id[i+1];
      end
      slot_count--;
    end
    res.occupancy = OCC_W'(slot_count);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Present one request at the falling edge, hold it until taken
  task automatic send_request(input req_t r, input logic has_result, input res_t want);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    request      <= r;
    typed_valid  <= has_result;
    typed_result <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Keys lean towards a few small values so ties are common
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return KEY_W'($urandom_range(0, 7));
      5:             return '1;
      6:             return '0;
      default:       return {$urandom, $urandom};
    endcase
  endfunction

  // Check results and record accepted requests at the rising edge
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst) begin
      idle_cycles++;
      if (done) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %h", $time, result);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("popped_id", 64'(want.popped_id), 64'(result.popped_id));
          check_field("pop_ok", 64'(want.pop_ok), 64'(result.pop_ok));
          check_field("push_dropped", 64'(want.push_dropped), 64'(result.push_dropped));
          check_field("occupancy", 64'(want.occupancy), 64'(result.occupancy));
          checked++;
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        want = apply_request(request);
        if (request.mode == MODE_PUSH) begin
          pushes++;
          if (want.push_dropped) refused++;
        end else begin
          pops++;
          if (!want.pop_ok) empty_pops++;
        end
        pending_results.push_back(typed_valid ? typed_result : want);
      end
    end
  end

  // End the run if nothing moves for too long
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("%0t ns: no request or result for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    req_t        r;
    int unsigned push_pct;
    plan = '{
      // pop on empty with the ignored fields set
      '{MODE_POP,  8'hA5, '1, '1, 5'd1, 1'b1, outcome(8'h00, 1'b0, 1'b0, 5'd0)},
      // largest key, then smallest key
      '{MODE_PUSH, 8'hFF, '1, '1, 5'd1, 1'b1, outcome(8'h00, 1'b0, 1'b0, 5'd1)},
      '{MODE_PUSH, 8'h00, '0, '0, 5'd1, 1'b0, '0},
      // equal keys leave in arrival order, sequence breaks a time tie
      '{MODE_PUSH, 8'h11, 64'd5, 64'd7, 5'd1, 1'b0, '0},
      '{MODE_PUSH, 8'h22, 64'd5, 64'd7, 5'd1, 1'b0, '0},
      '{MODE_PUSH, 8'h33, 64'd5, 64'd6, 5'd1, 1'b0, '0},
      '{MODE_PUSH, 8'h44, 64'd4, '1, 5'd1, 1'b0, '0},
      // drain, last pop finds the queue empty
      '{MODE_POP,  8'h00, '0, '0, 5'd7, 1'b0, '0},
      // fill with falling times so each lands at the head
      '{MODE_PUSH, 8'h80, 64'd1000, '0, 5'd16, 1'b0, '0},
      // push into a full queue is refused
      '{MODE_PUSH, 8'hAA, '0, '0, 5'd1, 1'b1, outcome(8'h00, 1'b0, 1'b1, 5'd16)},
      '{MODE_POP,  8'h00, '0, '0, 5'd16, 1'b0, '0},
      '{MODE_POP,  8'h5A, '0, '1, 5'd1, 1'b1, outcome(8'h00, 1'b0, 1'b0, 5'd0)}
    };

    // Hold reset, then release it at a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    gap_pct = 27;
    foreach (plan[row]) begin
      for (int k = 0; k < plan[row].reps; k++) begin
        r.mode            = plan[row].mode;
        r.request_id      = plan[row].id + REQ_ID_W'(k);
        r.request_time    = plan[row].req_time - KEY_W'(k);
        r.sequence_number = plan[row].req_seq;
        send_request(r, plan[row].has_result, plan[row].result);
      end
    end

    // Random requests; push bias shifts in runs so the queue swings between empty and full
    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BIAS_RUN == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      gap_pct = (n < PHASE_ITEMS) ? 27 : (n < 2 * PHASE_ITEMS) ? 81 : 0;
      r.mode            = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
      r.request_id      = REQ_ID_W'($urandom_range(0, 255));
      r.request_time    = pick_key();
      r.sequence_number = pick_key();
      send_request(r, 1'b0, '0);
    end
    start <= 1'b0;

    // Wait for the last results, then a little longer for strays
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d pushes (%0d refused when full) and %0d pops (%0d on empty);",
             pushes, refused, pops, empty_pops);
    $display("%0d results compared, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tsq_pkg.sv
rtl/tsq_cell.sv
rtl/timestamp_ordered_priority_queue.sv
bench/timestamp_ordered_priority_queue_tb.sv
